// ----- design/sts_pkg.sv -----
package sts_pkg;

    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [2:0] TK_EOS     = 3'd0;
    localparam logic [2:0] TK_DOT     = 3'd1;
    localparam logic [2:0] TK_SCOLON  = 3'd2;
    localparam logic [2:0] TK_COLON   = 3'd3;
    localparam logic [2:0] TK_LITERAL = 3'd4;
    localparam logic [2:0] TK_PREPROC = 3'd5;
    localparam logic [2:0] TK_NONE    = 3'd6;

    localparam int ALLOW_EOS     = 0;
    localparam int ALLOW_DOT     = 1;
    localparam int ALLOW_SCOLON  = 2;
    localparam int ALLOW_COLON   = 3;
    localparam int ALLOW_LITERAL = 4;
    localparam int ALLOW_PREPROC = 5;

    typedef struct packed {
        logic [1:0] cnt;
        logic [2:0] kind0;
        logic [2:0] kind1;
    } sts_push_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

endpackage

// ----- design/sts_core.sv -----
module sts_core
    import sts_pkg::*;
#(
    parameter int MAX_NEST_DEPTH = 255
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      character,
    input  logic            end_marker,
    input  logic [5:0]      allowed_tokens,
    input  logic            has_room,
    output sts_push_t       push
);

    localparam int DW = $clog2(MAX_NEST_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_NEST_DEPTH);

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_PERIOD  = 3'd1;
    localparam logic [2:0] MODE_COLON   = 3'd2;
    localparam logic [2:0] MODE_LIT     = 3'd3;
    localparam logic [2:0] MODE_LIT_ESC = 3'd4;
    localparam logic [2:0] MODE_BRACE   = 3'd5;

    logic            in_valid_reg, in_valid_next;
    logic [7:0]      char_reg;
    logic            end_reg;
    logic [5:0]      mask_reg;
    logic [2:0]      mode_reg, mode_next;
    logic            quote_dq_reg, quote_dq_next;
    logic [DW-1:0]   depth_reg, depth_next;

    logic            accept;
    logic            advance;
    logic            first_emit;
    logic [2:0]      first_kind;
    logic            run_idle;
    logic            idle_emit;
    logic            c_space;
    logic [7:0]      quote_ch;
    logic [DW-1:0]   depth_dec;

    assign advance  = in_valid_reg && has_room;
    assign in_stall = in_valid_reg && !has_room;
    assign accept   = in_valid && !in_stall;

    assign c_space  = is_space(char_reg);
    assign quote_ch = quote_dq_reg ? CH_DQUOTE : CH_SQUOTE;
    assign depth_dec = (depth_reg != '0) ? depth_reg - DW'(1) : depth_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        quote_dq_next = quote_dq_reg;
        depth_next    = depth_reg;
        first_emit    = 1'b0;
        first_kind    = TK_NONE;
        run_idle      = 1'b0;
        idle_emit     = 1'b0;

        if (end_reg)
        begin
            unique case (mode_reg)
                MODE_PERIOD:
                begin
                    first_emit = 1'b1;
                    first_kind = TK_EOS;
                end
                MODE_COLON:
                begin
                    first_emit = 1'b1;
                    first_kind = TK_COLON;
                end
                MODE_LIT, MODE_LIT_ESC:
                begin
                    first_emit = 1'b1;
                    first_kind = TK_LITERAL;
                end
                MODE_BRACE:
                begin
                    first_emit = 1'b1;
                    first_kind = TK_PREPROC;
                end
                default:
                begin
                    first_emit = 1'b0;
                end
            endcase
            mode_next  = MODE_IDLE;
            depth_next = '0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_PERIOD:
                begin
                    first_emit = 1'b1;
                    first_kind = c_space ? TK_EOS : TK_DOT;
                    run_idle   = 1'b1;
                end
                MODE_COLON:
                begin
                    first_emit = 1'b1;
                    first_kind = c_space ? TK_SCOLON : TK_COLON;
                    run_idle   = 1'b1;
                end
                MODE_LIT:
                begin
                    if (char_reg == quote_ch)
                    begin
                        first_emit = 1'b1;
                        first_kind = TK_LITERAL;
                        mode_next  = MODE_IDLE;
                    end
                    else if (char_reg == CH_TILDE)
                    begin
                        mode_next = MODE_LIT_ESC;
                    end
                end
                MODE_LIT_ESC:
                begin
                    mode_next = MODE_LIT;
                end
                MODE_BRACE:
                begin
                    if (char_reg == CH_RBRACE)
                    begin
                        depth_next = depth_dec;
                        if (depth_dec == '0)
                        begin
                            first_emit = 1'b1;
                            first_kind = TK_PREPROC;
                            mode_next  = MODE_IDLE;
                        end
                    end
                    else if (char_reg == CH_LBRACE)
                    begin
                        if (depth_reg < DEPTH_MAX)
                        begin
                            depth_next = depth_reg + DW'(1);
                        end
                    end
                end
                default:
                begin
                    run_idle = 1'b1;
                end
            endcase

            if (run_idle)
            begin
                mode_next = MODE_IDLE;
                if (!c_space)
                begin
                    if ((char_reg == CH_PERIOD) &&
                        (mask_reg[ALLOW_EOS] || mask_reg[ALLOW_DOT]))
                    begin
                        mode_next = MODE_PERIOD;
                    end
                    else if ((char_reg == CH_COLON) &&
                             (mask_reg[ALLOW_SCOLON] || mask_reg[ALLOW_COLON]))
                    begin
                        mode_next = MODE_COLON;
                    end
                    else if (((char_reg == CH_DQUOTE) || (char_reg == CH_SQUOTE)) &&
                             mask_reg[ALLOW_LITERAL])
                    begin
                        mode_next     = MODE_LIT;
                        quote_dq_next = (char_reg == CH_DQUOTE);
                    end
                    else if ((char_reg == CH_LBRACE) && mask_reg[ALLOW_PREPROC])
                    begin
                        mode_next  = MODE_BRACE;
                        depth_next = DW'(1);
                    end
                    else
                    begin
                        idle_emit = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        push.kind0 = first_emit ? first_kind : TK_NONE;
        push.kind1 = TK_NONE;
        if (!advance)
        begin
            push.cnt = 2'd0;
        end
        else
        begin
            push.cnt = {1'b0, first_emit} + {1'b0, idle_emit};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= character;
            end_reg  <= end_marker;
            mask_reg <= allowed_tokens;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_IDLE;
            quote_dq_reg <= 1'b0;
            depth_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                mode_reg     <= mode_next;
                quote_dq_reg <= quote_dq_next;
                depth_reg    <= depth_next;
            end
        end
    end

endmodule

// ----- design/sts_out_queue.sv -----
module sts_out_queue
    import sts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sts_push_t   push,
    output logic        has_room,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  token_kind,
    output logic        last_of_run
);

    logic [2:0] kind_reg [4];
    logic       last_reg [4];
    logic [1:0] head_reg, head_next;
    logic [1:0] tail_reg, tail_next;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [1:0] tail_plus1;

    assign out_valid   = (count_reg != 3'd0);
    assign pop         = out_valid && !out_stall;
    assign token_kind  = kind_reg[head_reg];
    assign last_of_run = last_reg[head_reg];
    assign has_room    = (count_reg <= 3'd2);
    assign tail_plus1  = tail_reg + 2'd1;

    always_comb
    begin
        head_next  = pop ? head_reg + 2'd1 : head_reg;
        tail_next  = tail_reg + push.cnt;
        count_next = count_reg + {1'b0, push.cnt} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            kind_reg[tail_reg] <= push.kind0;
            last_reg[tail_reg] <= (push.cnt == 2'd1);
        end
        if (push.cnt == 2'd2)
        begin
            kind_reg[tail_plus1] <= push.kind1;
            last_reg[tail_plus1] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 2'd0;
            tail_reg  <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- design/statement_token_scanner.sv -----
// Statement token scanner: one byte (or the end marker) per input word, with
// a mask of the token kinds allowed at that point; result words carry
// token_kind and last_of_run.
// Input channel: in_valid / in_stall with character, end_marker and
// allowed_tokens. A word is taken at a rising edge with in_valid high and
// in_stall low. Output channel: out_valid / out_stall with token_kind and
// last_of_run, same rule.
// Path: an input word is taken into the input register, then the scan logic
// writes its results into a four-entry result queue, which drives the
// output; a queue without room holds the input register back.
// Throughput: one input word per cycle while each word gives at most one
// result and out_stall stays low; results leave one per cycle, so words that
// give two results (a pending period or colon closed by a byte that is itself
// rejected) set a slower rate on the output side.
// Stall: the queue keeps taking input while it holds two results or fewer;
// beyond that in_stall rises until the receiver drains it. No result is lost.
// Reset: scan mode idle, quote flag and nesting depth cleared, queue empty.
module statement_token_scanner
    import sts_pkg::*;
#(
    parameter int MAX_NEST_DEPTH = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  character,
    input  logic        end_marker,
    input  logic [5:0]  allowed_tokens,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  token_kind,
    output logic        last_of_run
);

    sts_push_t push;
    logic      has_room;

    sts_core #(
        .MAX_NEST_DEPTH (MAX_NEST_DEPTH)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .character      (character),
        .end_marker     (end_marker),
        .allowed_tokens (allowed_tokens),
        .has_room       (has_room),
        .push           (push)
    );

    sts_out_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .has_room    (has_room),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .token_kind  (token_kind),
        .last_of_run (last_of_run)
    );

endmodule
